// ----- rtl/tcp_congestion_window_control_core_assert.svh -----
// Assertion helpers for the congestion window RTL.
`ifndef TCP_CONGESTION_WINDOW_CONTROL_CORE_ASSERT_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCWC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tcwc_pkg.sv -----
`default_nettype none

package tcwc_pkg;

   // Phase codes
   localparam logic [1:0] PH_SLOW    = 2'd0;
   localparam logic [1:0] PH_AVOID   = 2'd1;
   localparam logic [1:0] PH_RECOVER = 2'd2;

   localparam int PHASE_W = 2;
   localparam int ACKED_W = 16;
   localparam int DUP_W   = 2;

   localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;
   localparam int unsigned RECOVERY_BONUS = 3;

   // duplicate_ack, newly_acked, timeout = 18 bits, padded to 3 bytes
   localparam int REQ_DATA_W = 24;

   typedef logic [ACKED_W-1:0] acked_type;
   typedef logic [PHASE_W-1:0] phase_type;

endpackage

`default_nettype wire

// ----- rtl/tcp_congestion_window_control_core.sv -----
// Channel | Direction | Transfer contents
// req_    | in        | one ACK event: duplicate flag, newly acked count, timeout flag
// rsp_    | out       | window, threshold and phase after that event
//
// One event per cycle while rsp_ is not stalled; its result shows on rsp_ in the cycle after the transfer.
// The state update and the result register load at the same edge; the result
// is held in the single result register.
// req_tready is high while the result register is empty or being drained.
// reset is synchronous, active high: slow start, window 1, threshold initial.
// A stalled rsp_ holds its result and stalls req_ in the same cycle.
`default_nettype none

`include "tcp_congestion_window_control_core_assert.svh"

module tcp_congestion_window_control_core #(
   parameter int WINDOW_BITS       = 16,
   parameter int INITIAL_THRESHOLD = 16,
   localparam int RspDataW         = ((2 * WINDOW_BITS + tcwc_pkg::PHASE_W + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [0] duplicate_ack, [16:1] newly_acked, [17] timeout, rest zero
   input  wire logic [tcwc_pkg::REQ_DATA_W-1:0] req_tdata,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [WB-1:0] window, [2WB-1:WB] threshold, [2WB+1:2WB] phase, rest zero
   output      logic [RspDataW-1:0]             rsp_tdata
);
   import tcwc_pkg::*;

   localparam int WB = WINDOW_BITS;
   localparam int SW = ((WB > ACKED_W) ? WB : ACKED_W) + 1;
   localparam longint unsigned WinMaxL = (64'd1 << WB) - 64'd1;
   localparam logic [WB-1:0] WinMax = WB'(WinMaxL);
   localparam logic [SW-1:0] WinMaxS = SW'(WinMaxL);
   localparam longint unsigned ThrInitL = longint'(INITIAL_THRESHOLD);
   localparam logic [WB-1:0] ThrReset = (ThrInitL > WinMaxL) ? WinMax : WB'(ThrInitL);

   function automatic logic [WB-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW-1:0] s;
      s = a + b;
      return (s > WinMaxS) ? WinMax : s[WB-1:0];
   endfunction

   function automatic logic [WB-1:0] halve_floor1(input logic [WB-1:0] w);
      logic [WB-1:0] h;
      h = w >> 1;
      return (h == '0) ? WB'(1) : h;
   endfunction

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [WB-1:0]      window_ff, window_in;
   logic [WB-1:0]      threshold_ff, threshold_in;
   logic [DUP_W-1:0]   dup_ff, dup_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic      req_xfer;
   logic      ev_dup;
   logic      ev_tmo;
   acked_type ev_acked;

   assign ev_dup   = req_tdata[0];
   assign ev_acked = req_tdata[ACKED_W:1];
   assign ev_tmo   = req_tdata[ACKED_W+1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // Checks in the same order as the protocol rules; later ones see earlier updates.
   always_comb begin
      logic [PHASE_W-1:0] ph;
      logic [WB-1:0]      win;
      logic [WB-1:0]      thr;
      logic [DUP_W-1:0]   dc;
      ph  = phase_ff;
      win = window_ff;
      thr = threshold_ff;
      dc  = dup_ff;
      case (phase_ff)
         PH_SLOW: begin
            if (ev_dup && dc != DUP_LIMIT) begin
               dc = dc + DUP_W'(1);
            end
            if (ev_acked != '0) begin
               win = sat_add(SW'(win), SW'(ev_acked));
               dc  = '0;
            end
            if (ev_tmo) begin
               thr = halve_floor1(win);
               win = WB'(1);
               dc  = '0;
            end
            if (win >= thr) begin
               ph = PH_AVOID;
            end
            if (dc == DUP_LIMIT) begin
               thr = halve_floor1(win);
               win = sat_add(SW'(thr), SW'(RECOVERY_BONUS));
               ph  = PH_RECOVER;
            end
         end
         PH_AVOID: begin
            if (SW'(ev_acked) == SW'(win)) begin
               win = sat_add(SW'(win), SW'(1));
               dc  = '0;
            end
            if (ev_dup && dc != DUP_LIMIT) begin
               dc = dc + DUP_W'(1);
            end
            if (ev_tmo) begin
               thr = halve_floor1(win);
               win = WB'(1);
               dc  = '0;
               ph  = PH_SLOW;
            end
            if (dc == DUP_LIMIT) begin
               thr = halve_floor1(win);
               win = sat_add(SW'(thr), SW'(RECOVERY_BONUS));
               ph  = PH_RECOVER;
            end
         end
         PH_RECOVER: begin
            if (ev_dup) begin
               win = sat_add(SW'(win), SW'(1));
            end
            if (ev_tmo) begin
               thr = halve_floor1(win);
               win = WB'(1);
               dc  = '0;
               ph  = PH_SLOW;
            end
            if (ev_acked != '0) begin
               win = thr;
               dc  = '0;
               ph  = PH_AVOID;
            end
         end
         default: begin
            // unused code: hold everything
         end
      endcase

      if (req_xfer) begin
         phase_in     = ph;
         window_in    = win;
         threshold_in = thr;
         dup_in       = dc;
         rsp_data_in  = RspDataW'({ph, thr, win});
      end else begin
         phase_in     = phase_ff;
         window_in    = window_ff;
         threshold_in = threshold_ff;
         dup_in       = dup_ff;
         rsp_data_in  = rsp_data_ff;
      end

      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SLOW;
         window_ff    <= WB'(1);
         threshold_ff <= ThrReset;
         dup_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TCWC_ASSERT_SAME(a_window_nonzero, clock, reset, 1'b1, window_ff != '0,
                     "window reached zero")
   `TCWC_ASSERT_SAME(a_threshold_nonzero, clock, reset, 1'b1, threshold_ff != '0,
                     "threshold reached zero")
   `TCWC_ASSERT_NEXT(a_timeout_collapse, clock, reset,
                     req_xfer && ev_tmo && ev_acked == '0,
                     window_ff == WB'(1), "timeout did not collapse window")
   `TCWC_ASSERT_NEXT(a_result_matches_state, clock, reset, req_xfer,
                     rsp_valid_ff && rsp_data_ff[WB-1:0] == window_ff
                     && rsp_data_ff[2*WB-1:WB] == threshold_ff,
                     "result differs from state")

endmodule

`default_nettype wire

// ----- tb/tcp_congestion_window_control_core_tb.sv -----
module tcp_congestion_window_control_core_tb;
   import tcwc_pkg::*;

   localparam int WB            = 16;
   localparam int INIT_THRESH   = 16;
   localparam int RSP_W         = ((2 * WB + PHASE_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ACKS   = 600;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [WB-1:0] win_type;

   typedef struct packed {
      phase_type phase;
      win_type   threshold;
      win_type   window;
   } cwnd_result_type;

   class cwnd_scoreboard;
      phase_type       phase;
      win_type         cwnd;
      win_type         ssthresh;
      logic [DUP_W-1:0] dups;
      cwnd_result_type expected[$];
      int              errors;

      function new();
         phase    = PH_SLOW;
         cwnd     = win_type'(1);
         ssthresh = win_type'(INIT_THRESH);
         dups     = '0;
         errors   = 0;
      endfunction

      function win_type sat_add(win_type a, win_type b);
         logic [WB:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[WB] ? '1 : s[WB-1:0];
      endfunction

      function win_type half_floor1(win_type w);
         return ((w >> 1) == 0) ? win_type'(1) : (w >> 1);
      endfunction

      function void cut_on_timeout();
         ssthresh = half_floor1(cwnd);
         cwnd     = win_type'(1);
         dups     = '0;
      endfunction

      function void start_recovery();
         ssthresh = half_floor1(cwnd);
         cwnd     = sat_add(ssthresh, win_type'(RECOVERY_BONUS));
         phase    = PH_RECOVER;
      endfunction

      // Advance the window state by one accepted ACK event and queue its result.
      function void note_ack(logic dup, acked_type acked, logic tmo);
         cwnd_result_type r;
         case (phase)
            PH_SLOW: begin
               if (dup && dups != DUP_LIMIT) dups++;
               if (acked != 0) begin
                  cwnd = sat_add(cwnd, win_type'(acked));
                  dups = '0;
               end
               if (tmo) cut_on_timeout();
               if (cwnd >= ssthresh) phase = PH_AVOID;
               if (dups == DUP_LIMIT) start_recovery();
            end
            PH_AVOID: begin
               if (win_type'(acked) == cwnd) begin
                  cwnd = sat_add(cwnd, win_type'(1));
                  dups = '0;
               end
               if (dup && dups != DUP_LIMIT) dups++;
               if (tmo) begin
                  cut_on_timeout();
                  phase = PH_SLOW;
               end
               if (dups == DUP_LIMIT) start_recovery();
            end
            PH_RECOVER: begin
               if (dup) cwnd = sat_add(cwnd, win_type'(1));
               if (tmo) begin
                  cut_on_timeout();
                  phase = PH_SLOW;
               end
               if (acked != 0) begin
                  cwnd  = ssthresh;
                  dups  = '0;
                  phase = PH_AVOID;
               end
            end
            default: ;
         endcase
         r.window    = cwnd;
         r.threshold = ssthresh;
         r.phase     = phase;
         expected.push_back(r);
      endfunction

      function void check_result(logic [RSP_W-1:0] d);
         cwnd_result_type e;
         win_type         w_got;
         win_type         t_got;
         phase_type       p_got;
         w_got = d[WB-1:0];
         t_got = d[2*WB-1:WB];
         p_got = d[2*WB+PHASE_W-1:2*WB];
         if (expected.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result transfer: window %0d threshold %0d phase %0d",
                        w_got, t_got, p_got);
            return;
         end
         e = expected.pop_front();
         if (w_got !== e.window || t_got !== e.threshold || p_got !== e.phase) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"mismatch: window exp %0d got %0d, threshold exp %0d got %0d,",
                         " phase exp %0d got %0d"},
                        e.window, w_got, e.threshold, t_got, e.phase, p_got);
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;

   cwnd_scoreboard sb;
   bit             steady;
   int unsigned    cycles;

   tcp_congestion_window_control_core #(
      .WINDOW_BITS      (WB),
      .INITIAL_THRESHOLD(INIT_THRESH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap, sometimes a few cycles, rarely a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Receiver back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 3) == 0) hold = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_ack(req_tdata[0], req_tdata[ACKED_W:1], req_tdata[ACKED_W+1]);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tcp_congestion_window_control_core_tb: errors");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_ack(logic dup, acked_type acked, logic tmo);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {{(REQ_DATA_W - ACKED_W - 2){1'b0}}, tmo, acked, dup};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the sender until every queued result has drained.
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(int total);
      int sent;
      int kind;
      int n;
      acked_type a;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 39) == 0) steady = !steady;
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // growth: often ack exactly the window so avoidance moves
            n = $urandom_range(1, 6);
            repeat (n) begin
               a = $urandom_range(0, 1) ? acked_type'(sb.cwnd)
                                        : acked_type'($urandom_range(1, 8));
               send_ack($urandom_range(0, 7) == 0, a, 1'b0);
            end
            sent += n;
         end else if (kind < 65) begin
            n = $urandom_range(3, 5);
            repeat (n) send_ack(1'b1, '0, 1'b0);
            sent += n;
            case ($urandom_range(0, 2))
               0: begin
                  send_ack(1'b0, acked_type'($urandom_range(1, 4)), 1'b0);
                  sent++;
               end
               1: begin
                  send_ack(1'($urandom_range(0, 1)), '0, 1'b1);
                  sent++;
               end
               default: ;
            endcase
         end else if (kind < 75) begin
            send_ack(1'($urandom_range(0, 1)), acked_type'($urandom_range(0, 3)), 1'b1);
            sent++;
         end else begin
            send_ack(1'($urandom_range(0, 1)), acked_type'($urandom),
                     $urandom_range(0, 3) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      sb         = new();
      steady     = 1'b0;
      cycles     = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: saturation, dup-driven recovery, floor of 1, timeouts in each phase
      send_ack(1'b0, 16'd0, 1'b0);
      send_ack(1'b0, 16'hFFFF, 1'b0);
      send_ack(1'b0, 16'hFFFF, 1'b0);
      repeat (3) send_ack(1'b1, 16'd0, 1'b0);
      send_ack(1'b1, 16'd0, 1'b0);
      send_ack(1'b0, 16'd1, 1'b0);
      send_ack(1'b0, 16'd0, 1'b1);
      send_ack(1'b0, 16'd0, 1'b1);
      repeat (3) send_ack(1'b1, 16'd0, 1'b0);
      send_ack(1'b1, 16'd0, 1'b1);
      send_ack(1'b0, 16'h5555, 1'b0);
      send_ack(1'b0, 16'hAAAA, 1'b0);
      send_ack(1'b1, 16'hFFFF, 1'b1);
      repeat (3) send_ack(1'b1, 16'd0, 1'b0);
      send_ack(1'b0, 16'd7, 1'b1);
      send_ack(1'b0, 16'd0, 1'b0);
      drain_results();

      run_random(RANDOM_ACKS / 2);
      drain_results();
      run_random(RANDOM_ACKS / 2);
      req_tvalid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tcp_congestion_window_control_core_tb: clean");
      else
         $display("tcp_congestion_window_control_core_tb: errors");
      $finish;
   end

endmodule

// ----- tcp_congestion_window_control_core.f -----
+incdir+rtl
rtl/tcwc_pkg.sv
rtl/tcp_congestion_window_control_core.sv
tb/tcp_congestion_window_control_core_tb.sv
